// ===== sv/pogb_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and a helper function for the occupancy grid binner
// no dependencies

package pogb_pkg;

  localparam int GRID_SIDE_DEF    = 50;
  localparam int CELL_SIZE_MM_DEF = 100;
  localparam int Y_OFFSET_MM_DEF  = 2500;

  localparam int CNT_W     = 8;
  localparam int COORD_W   = 16;
  localparam int COLOUR_W  = 8;
  localparam int LIMIT_W   = 7;
  localparam int CIDX_W    = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  // magnitude of a coordinate after offset, before division
  localparam int MAG_W     = 17;

  localparam logic signed [COORD_W-1:0] HEIGHT_LOW_RST  = -16'sd300;
  localparam logic signed [COORD_W-1:0] HEIGHT_HIGH_RST = 16'sd300;
  localparam logic [COLOUR_W-1:0]       COLOUR_THR_RST  = 8'd150;
  localparam logic signed [CNT_W-1:0]   OCC_THR_RST     = 8'sd70;
  localparam logic [LIMIT_W-1:0]        COUNT_LIMIT_RST = 7'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEIGHT_LOW  = 3'd0,
    CFG_HEIGHT_HIGH = 3'd1,
    CFG_COLOUR_THR  = 3'd2,
    CFG_OCC_THR     = 3'd3,
    CFG_COUNT_LIMIT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic clr_we;
    logic latch;
    logic mul;
    logic chk;
    logic fix;
    logic idx;
    logic rd;
    logic wr;
  } pogb_cmd_t;

  typedef struct packed {
    logic clr_last;
  } pogb_sts_t;

  // value a cell holds after reset and after a read
  function automatic logic signed [CNT_W-1:0] pogb_init_value(input logic [15:0] idx,
                                                              input logic [15:0] side);
    logic [16:0] dbl;
    logic signed [CNT_W-1:0] val;
    dbl = {idx, 1'b0};
    if (idx < side) begin
      val = (dbl > 17'd127) ? 8'sd127 : CNT_W'(dbl);
    end else begin
      val = -8'sd1;
    end
    return val;
  endfunction

endpackage

// ===== sv/pogb_ram.sv =====
`timescale 1ns / 1ps
// generic single write, single read port ram with registered read data
// no dependencies

module pogb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2500
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/pogb_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine for the occupancy grid binner
// depends on pogb_pkg

module pogb_ctrl
  import pogb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_kind,
  input  pogb_sts_t sts,
  output pogb_cmd_t cmd,
  output logic      busy
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_CHK   = 8'b0000_1000,
    S_FIX   = 8'b0001_0000,
    S_IDX   = 8'b0010_0000,
    S_RD    = 8'b0100_0000,
    S_WR    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = in_kind ? S_RD : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.idx   = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_wr_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WR |=> state_r == S_IDLE)
    else $error("write state not followed by idle");

  a_point_path: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_kind) |=> state_r == S_MUL)
    else $error("point transaction did not enter multiply state");

  a_read_path: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind) |=> state_r == S_RD)
    else $error("read transaction did not go to memory read");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && sts.clr_last) |=> state_r == S_IDLE)
    else $error("clearing pass did not end in idle");

endmodule

// ===== sv/pogb_dp.sv =====
`timescale 1ns / 1ps
// datapath: config registers, gating, binning by reciprocal multiply, cell store
// depends on pogb_pkg and pogb_ram

module pogb_dp
  import pogb_pkg::*;
#(
  parameter int GRID_SIDE    = GRID_SIDE_DEF,
  parameter int CELL_SIZE_MM = CELL_SIZE_MM_DEF,
  parameter int Y_OFFSET_MM  = Y_OFFSET_MM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pogb_cmd_t                  cmd,
  output pogb_sts_t                  sts,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_data,
  input  logic                       in_kind,
  input  logic signed [COORD_W-1:0]  in_x_mm,
  input  logic signed [COORD_W-1:0]  in_y_mm,
  input  logic signed [COORD_W-1:0]  in_z_mm,
  input  logic [COLOUR_W-1:0]        in_red,
  input  logic [COLOUR_W-1:0]        in_green,
  input  logic [COLOUR_W-1:0]        in_blue,
  input  logic [CIDX_W-1:0]          in_cell_index,
  output logic                       out_valid,
  output logic                       out_counted,
  output logic                       out_occupied,
  output logic signed [CNT_W-1:0]    out_cell_count
);

  localparam int CELLS      = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int DIV_SHIFT  = MAG_W + $clog2(CELL_SIZE_MM) + 1;
  localparam int MULT_W     = MAG_W + 2;
  localparam int PROD_W     = MAG_W + MULT_W;
  localparam int D_W        = $clog2(CELL_SIZE_MM + 1);
  localparam int QD_W       = MAG_W + D_W;
  localparam int P_W        = MAG_W + 1;
  localparam int G_W        = $clog2(GRID_SIDE + 1) + 1;
  localparam int IDX_W      = P_W + G_W + 1;
  localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'((64'd1 << DIV_SHIFT) / CELL_SIZE_MM);
  localparam logic [D_W-1:0]    DIVISOR  = D_W'(CELL_SIZE_MM);
  localparam logic signed [IDX_W-1:0] SIDE_S  = IDX_W'(GRID_SIDE);
  localparam logic signed [IDX_W-1:0] CELLS_S = IDX_W'(CELLS);

  // config registers
  logic signed [COORD_W-1:0] height_low_r, height_high_r;
  logic [COLOUR_W-1:0]       colour_thr_r;
  logic signed [CNT_W-1:0]   occ_thr_r;
  logic [LIMIT_W-1:0]        count_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_low_r  <= HEIGHT_LOW_RST;
      height_high_r <= HEIGHT_HIGH_RST;
      colour_thr_r  <= COLOUR_THR_RST;
      occ_thr_r     <= OCC_THR_RST;
      count_limit_r <= COUNT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEIGHT_LOW:  height_low_r  <= cfg_data;
        CFG_HEIGHT_HIGH: height_high_r <= cfg_data;
        CFG_COLOUR_THR:  colour_thr_r  <= cfg_data[COLOUR_W-1:0];
        CFG_OCC_THR:     occ_thr_r     <= cfg_data[CNT_W-1:0];
        CFG_COUNT_LIMIT: count_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input gating and coordinate magnitudes
  logic                     pass;
  logic signed [MAG_W-1:0]  x_ext;
  logic signed [MAG_W:0]    y_sum;
  logic [MAG_W-1:0]         mag_x, mag_y;
  logic [31:0]              cidx_ext;
  logic                     cidx_ok;

  assign pass = (in_z_mm >= height_low_r) && (in_z_mm <= height_high_r) &&
                (in_red > colour_thr_r) && (in_green > colour_thr_r) &&
                (in_blue > colour_thr_r);
  assign x_ext    = {in_x_mm[COORD_W-1], in_x_mm};
  assign y_sum    = {{2{in_y_mm[COORD_W-1]}}, in_y_mm} + (MAG_W+1)'(Y_OFFSET_MM);
  assign mag_x    = x_ext[MAG_W-1] ? MAG_W'(-x_ext) : MAG_W'(x_ext);
  assign mag_y    = y_sum[MAG_W] ? MAG_W'(-y_sum) : MAG_W'(y_sum);
  assign cidx_ext = 32'(in_cell_index);
  assign cidx_ok  = cidx_ext < 32'(CELLS);

  logic                    kind_r, pass_r, neg_x_r, neg_y_r;
  logic [MAG_W-1:0]        mag_x_r, mag_y_r;
  logic [PROD_W-1:0]       prod_x_r, prod_y_r;
  logic [MAG_W-1:0]        q_x_r, q_y_r;
  logic [QD_W-1:0]         qd_x_r, qd_y_r;
  logic signed [P_W-1:0]   px_r, py_r;
  logic [ADDR_W-1:0]       addr_r;
  logic                    hit_r;

  logic [MAG_W-1:0]        q_x, q_y, qc_x, qc_y;
  logic [QD_W-1:0]         rem_x, rem_y;
  logic signed [IDX_W-1:0] idx_full;

  assign q_x   = MAG_W'(prod_x_r >> DIV_SHIFT);
  assign q_y   = MAG_W'(prod_y_r >> DIV_SHIFT);
  assign rem_x = QD_W'(mag_x_r) - qd_x_r;
  assign rem_y = QD_W'(mag_y_r) - qd_y_r;
  assign qc_x  = q_x_r + MAG_W'(rem_x >= QD_W'(DIVISOR));
  assign qc_y  = q_y_r + MAG_W'(rem_y >= QD_W'(DIVISOR));
  assign idx_full = IDX_W'(px_r) + IDX_W'(py_r) * SIDE_S;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r  <= in_kind;
      pass_r  <= pass;
      neg_x_r <= x_ext[MAG_W-1];
      neg_y_r <= y_sum[MAG_W];
      mag_x_r <= mag_x;
      mag_y_r <= mag_y;
      hit_r   <= in_kind & cidx_ok;
      addr_r  <= cidx_ext[ADDR_W-1:0];
    end
    if (cmd.mul) begin
      prod_x_r <= PROD_W'(mag_x_r) * PROD_W'(DIV_MULT);
      prod_y_r <= PROD_W'(mag_y_r) * PROD_W'(DIV_MULT);
    end
    if (cmd.chk) begin
      q_x_r  <= q_x;
      q_y_r  <= q_y;
      qd_x_r <= QD_W'(q_x) * QD_W'(DIVISOR);
      qd_y_r <= QD_W'(q_y) * QD_W'(DIVISOR);
    end
    if (cmd.fix) begin
      px_r <= neg_x_r ? -$signed({1'b0, qc_x}) : $signed({1'b0, qc_x});
      py_r <= neg_y_r ? -$signed({1'b0, qc_y}) : $signed({1'b0, qc_y});
    end
    if (cmd.idx) begin
      hit_r  <= pass_r && (idx_full > 0) && (idx_full < CELLS_S);
      addr_r <= idx_full[ADDR_W-1:0];
    end
  end

  // clearing pass counter
  logic [ADDR_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clr_last = (32'(clr_cnt_r) == 32'(CELLS - 1));

  // cell store
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [CNT_W-1:0]        ram_wdata;
  logic [CNT_W-1:0]        ram_rdata;
  logic signed [CNT_W-1:0] cur;
  logic signed [CNT_W:0]   inc, lim;
  logic signed [CNT_W:0]   sat;

  assign cur = $signed(ram_rdata);
  assign inc = {cur[CNT_W-1], cur} + 9'sd1;
  assign lim = $signed({2'b00, count_limit_r});
  assign sat = (inc > lim) ? lim : inc;

  always_comb begin
    if (cmd.clr_we) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = pogb_init_value(16'(clr_cnt_r), 16'(GRID_SIDE));
    end else begin
      ram_we    = cmd.wr & hit_r;
      ram_waddr = addr_r;
      ram_wdata = kind_r ? pogb_init_value(16'(addr_r), 16'(GRID_SIDE))
                         : sat[CNT_W-1:0];
    end
  end

  pogb_ram #(
    .WIDTH(CNT_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  // result register
  logic                    out_valid_r;
  logic                    out_counted_r, out_occupied_r;
  logic signed [CNT_W-1:0] out_cell_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      out_counted_r    <= !kind_r && hit_r;
      out_occupied_r   <= kind_r && hit_r && (cur > occ_thr_r);
      out_cell_count_r <= (kind_r && hit_r) ? cur : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_counted    = out_counted_r;
  assign out_occupied   = out_occupied_r;
  assign out_cell_count = out_cell_count_r;

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_counted_r && out_occupied_r))
    else $error("result marks both counted and occupied");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr && hit_r && !kind_r) |-> $signed({1'b0, ram_wdata}) <= lim)
    else $error("cell count written above limit");

  a_point_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_counted_r) |-> out_cell_count_r == '0)
    else $error("point result carries a cell count");

endmodule

// ===== sv/point_occupancy_grid_binner_unit.sv =====
`timescale 1ns / 1ps
// top level of the occupancy grid binner: controller, datapath and cell store
// depends on pogb_pkg, pogb_ctrl, pogb_dp, pogb_ram
//
// usage
//   input: drive in_* and raise start; the transaction is taken on a rising
//   edge with start high and busy low. in_kind 0 bins a point, 1 reads a cell
//   and restores its initial value.
//   result: one per transaction, shown for exactly one cycle with out_valid
//   high; the receiver cannot stall, so it must take it in that cycle.
//   config: cfg_valid, cfg_index, cfg_data; cfg_ready is always high. write
//   only while no transaction is in flight.
//   sequence: a point result follows the reciprocal multiply, remainder
//   check and correction, grid index multiply, then the read and write of
//   the cell store; a read result follows only the read and write. busy
//   drops the cycle the result appears, so a new transaction is taken only
//   once the result of the last one is out.
//   reset: synchronous, active low. config returns to defaults and a clearing
//   pass loads initial values into all GRID_SIDE*GRID_SIDE cells (2500 by
//   default); busy stays high and no transaction is taken until it ends.

module point_occupancy_grid_binner_unit
  import pogb_pkg::*;
#(
  parameter int GRID_SIDE    = GRID_SIDE_DEF,
  parameter int CELL_SIZE_MM = CELL_SIZE_MM_DEF,
  parameter int Y_OFFSET_MM  = Y_OFFSET_MM_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_kind,
  input  logic signed [COORD_W-1:0]  in_x_mm,
  input  logic signed [COORD_W-1:0]  in_y_mm,
  input  logic signed [COORD_W-1:0]  in_z_mm,
  input  logic [COLOUR_W-1:0]        in_red,
  input  logic [COLOUR_W-1:0]        in_green,
  input  logic [COLOUR_W-1:0]        in_blue,
  input  logic [CIDX_W-1:0]          in_cell_index,
  output logic                       out_valid,
  output logic                       out_counted,
  output logic                       out_occupied,
  output logic signed [CNT_W-1:0]    out_cell_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_data
);

  pogb_cmd_t cmd;
  pogb_sts_t sts;

  assign cfg_ready = 1'b1;

  pogb_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_kind(in_kind),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  pogb_dp #(
    .GRID_SIDE   (GRID_SIDE),
    .CELL_SIZE_MM(CELL_SIZE_MM),
    .Y_OFFSET_MM (Y_OFFSET_MM)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_kind       (in_kind),
    .in_x_mm       (in_x_mm),
    .in_y_mm       (in_y_mm),
    .in_z_mm       (in_z_mm),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_cell_index (in_cell_index),
    .out_valid     (out_valid),
    .out_counted   (out_counted),
    .out_occupied  (out_occupied),
    .out_cell_count(out_cell_count)
  );

endmodule
